### sv/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u2u_pkg;

	localparam int UNIT_W = 16;
	localparam int ACC_W  = 21;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BOM    = 1'd1;

	localparam logic [UNIT_W-1:0] REPL_RESET = 16'hFFFD;

	// result status codes
	localparam logic [1:0] ST_VALID      = 2'd0;
	localparam logic [1:0] ST_REPL       = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;

	localparam logic [ACC_W-1:0] BOM_VALUE  = 21'h00FEFF;
	localparam logic [ACC_W-1:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [ACC_W-1:0] SUPP_BASE  = 21'h010000;
	localparam logic [ACC_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [ACC_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [ACC_W-1:0] NC_LO      = 21'h00FDD0;
	localparam logic [ACC_W-1:0] NC_HI      = 21'h00FDEF;
	localparam logic [UNIT_W-1:0] HI_OFFSET = 16'hD7C0;
	localparam logic [UNIT_W-1:0] LO_OFFSET = 16'hDC00;

	typedef enum logic [1:0] {
		MK_NONE,
		MK_UNIT,
		MK_PAIR,
		MK_BAD
	} main_kind_t;

	// one decoded byte: prefix replacements, main result, end marker
	typedef struct packed {
		logic [1:0]       nbad;
		main_kind_t       kind;
		logic [ACC_W-1:0] value;
		logic             incomplete;
		logic             fin;
	} job_t;

endpackage

### sv/u2u_byte_if.sv
// Byte channel: one UTF-8 byte per word.
interface u2u_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       final_byte;

	modport source(output valid, byte_value, final_byte, input ready);
	modport sink(input valid, byte_value, final_byte, output ready);
endinterface

### sv/u2u_unit_if.sv
// Unit channel: one UTF-16 code unit with status per word.
interface u2u_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic [15:0] invalid_total;
	logic        run_end;

	modport source(output valid, code_unit, status, invalid_total, run_end, input ready);
	modport sink(input valid, code_unit, status, invalid_total, run_end, output ready);
endinterface

### sv/utf8_to_utf16_stream_decoder.sv
// UTF-8 to UTF-16 stream decoder: takes one UTF-8 byte per word on bytes_ch and
// returns UTF-16 code units on units_ch; a scalar above the BMP gives a surrogate pair,
// each malformed sequence, overlong form, surrogate, noncharacter or out-of-range value
// gives the replacement unit (config register 0), a broken sequence gives one replacement
// per byte taken before its breaking byte is decoded afresh, a leading byte order mark is
// dropped when register 1 is set, and a final byte that leaves a sequence open adds an
// incomplete marker (unit 0, status 2) and returns the decoder to its start state.
// Rate: one byte is accepted every cycle while the job queue has room; the back end sends
// one unit per cycle while units_ch is ready, so a byte that yields several units (at most
// four) keeps it busy until all are sent. Bytes that yield nothing take no back-end slot,
// except a final byte, whose job still passes through the back end to clear the invalid
// count. The job queue (QUEUE_DEPTH entries) lets the front keep taking bytes during such
// bursts or while units_ch stalls; once it is full, bytes_ch.ready drops, also in a cycle
// where the back end frees an entry. With an empty queue, a byte's job is written to the
// queue and its unit then to the output register before the word is valid. Config writes
// take effect at once, so make them only while the block is idle (queue empty, no unit word waiting).
module utf8_to_utf16_stream_decoder
	import u2u_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [UNIT_W-1:0]    cfg_data,
	u2u_byte_if.sink             bytes_ch,
	u2u_unit_if.source           units_ch
);

	// configuration registers
	logic [UNIT_W-1:0] repl_q;
	logic              skip_bom_q;

	// front to queue
	job_t push_job;
	logic push;
	logic full;

	// queue to back
	job_t head;
	logic empty;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
			skip_bom_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REPLACEMENT: repl_q <= cfg_data;
				CFG_SKIP_BOM:    skip_bom_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// decode state and byte classification
	u2u_front front_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (bytes_ch.valid),
		.byte_value (bytes_ch.byte_value),
		.final_byte (bytes_ch.final_byte),
		.ready      (bytes_ch.ready),
		.skip_bom   (skip_bom_q),
		.full       (full),
		.push       (push),
		.job        (push_job)
	);

	// decouples byte intake from unit output
	u2u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) queue_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// unit expansion, invalid count, output register
	u2u_back back_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.repl_unit     (repl_q),
		.valid         (units_ch.valid),
		.ready         (units_ch.ready),
		.code_unit     (units_ch.code_unit),
		.status        (units_ch.status),
		.invalid_total (units_ch.invalid_total),
		.run_end       (units_ch.run_end)
	);

endmodule

### sv/u2u_front.sv
// Front end: accepts bytes, tracks the open sequence, classifies each byte into a job.
module u2u_front
	import u2u_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic [7:0] byte_value,
	input  logic       final_byte,
	output logic       ready,
	input  logic       skip_bom,
	input  logic       full,
	output logic       push,
	output job_t       job
);

	logic [1:0]       bn_q, bn_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic [1:0]       sl_q, sl_n;
	logic [1:0]       ct_q, ct_n;
	logic             fd_q, fd_n;

	logic             accept;
	logic             do_lead;
	logic             is_cont;
	logic [ACC_W-1:0] v;
	logic [ACC_W-1:0] lowest;
	logic             nc;
	job_t             j;

	assign ready   = !full;
	assign accept  = valid && ready;
	assign is_cont = (byte_value[7:6] == 2'b10);
	assign v       = {acc_q[ACC_W-7:0], byte_value[5:0]};

	always_comb begin
		unique case (sl_q)
			2'd1:    lowest = 21'h000080;
			2'd2:    lowest = 21'h000800;
			default: lowest = SUPP_BASE;
		endcase
		nc = (v >= NC_LO) && ((v <= NC_HI) || (v[15:1] == 15'h7FFF));
	end

	always_comb begin
		bn_n = bn_q;
		acc_n = acc_q;
		sl_n = sl_q;
		ct_n = ct_q;
		fd_n = fd_q;
		do_lead = 1'b0;
		j = '0;
		j.kind = MK_NONE;
		j.fin = final_byte;

		if (bn_q != 2'd0 && is_cont) begin
			acc_n = v;
			bn_n = bn_q - 2'd1;
			ct_n = ct_q + 2'd1;
			if (bn_q == 2'd1) begin
				j.value = v;
				if (!fd_q && v == BOM_VALUE && skip_bom) begin
					j.kind = MK_NONE;
				end else if (!nc && v >= SUPP_BASE && v <= MAX_SCALAR) begin
					j.kind = MK_PAIR;
				end else if (v < lowest || (v >= SURR_LO && v <= SURR_HI) || nc
						|| v > MAX_SCALAR) begin
					j.kind = MK_BAD;
				end else begin
					j.kind = MK_UNIT;
				end
				fd_n = 1'b1;
				ct_n = 2'd0;
			end
		end else begin
			do_lead = 1'b1;
			if (bn_q != 2'd0) begin
				// broken sequence: one replacement per byte taken
				j.nbad = ct_q + 2'd1;
				bn_n = 2'd0;
				fd_n = 1'b1;
			end
		end

		if (do_lead) begin
			ct_n = 2'd0;
			unique case (byte_value) inside
				8'b0???????: begin
					j.kind = MK_UNIT;
					j.value = {13'd0, byte_value};
					fd_n = 1'b1;
				end
				8'b110?????: begin
					acc_n = {16'd0, byte_value[4:0]};
					bn_n = 2'd1;
					sl_n = 2'd1;
					fd_n = 1'b1;
				end
				8'b1110????: begin
					acc_n = {17'd0, byte_value[3:0]};
					bn_n = 2'd2;
					sl_n = 2'd2;
				end
				8'b11110???: begin
					acc_n = {18'd0, byte_value[2:0]};
					bn_n = 2'd3;
					sl_n = 2'd3;
					fd_n = 1'b1;
				end
				default: begin
					j.kind = MK_BAD;
					fd_n = 1'b1;
				end
			endcase
		end

		if (final_byte) begin
			j.incomplete = (bn_n != 2'd0);
			bn_n = 2'd0;
			acc_n = '0;
			sl_n = 2'd0;
			ct_n = 2'd0;
			fd_n = 1'b0;
		end
	end

	assign job  = j;
	assign push = accept && (j.kind != MK_NONE || j.nbad != 2'd0 || j.incomplete || j.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bn_q <= '0;
			acc_q <= '0;
			sl_q <= '0;
			ct_q <= '0;
			fd_q <= 1'b0;
		end else if (accept) begin
			bn_q <= bn_n;
			acc_q <= acc_n;
			sl_q <= sl_n;
			ct_q <= ct_n;
			fd_q <= fd_n;
		end
	end

endmodule

### sv/u2u_queue.sv
// Small register FIFO of jobs between front and back.
module u2u_queue
	import u2u_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### sv/u2u_back.sv
// Back end: expands each job into code units, keeps the invalid count, output register.
module u2u_back
	import u2u_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  logic        empty,
	output logic        pop,
	input  logic [15:0] repl_unit,
	output logic        valid,
	input  logic        ready,
	output logic [15:0] code_unit,
	output logic [1:0]  status,
	output logic [15:0] invalid_total,
	output logic        run_end
);

	logic [1:0]  idx_q;
	logic [15:0] cnt_q;
	logic        ov_q;
	logic [15:0] unit_q, tot_q;
	logic [1:0]  st_q;
	logic        end_q;

	logic [2:0]  nb, mlen, total, pos, jrel;
	logic        last, step, emit, slot_free;
	logic [15:0] unit_c, cnt_inc;
	logic [1:0]  st_c;

	assign nb = {1'b0, head.nbad};
	assign pos = {1'b0, idx_q};
	assign jrel = pos - nb;

	always_comb begin
		unique case (head.kind)
			MK_NONE:         mlen = 3'd0;
			MK_UNIT, MK_BAD: mlen = 3'd1;
			MK_PAIR:         mlen = 3'd2;
			default:         mlen = 3'd0;
		endcase
		total = nb + mlen + {2'd0, head.incomplete};
	end

	always_comb begin
		if (pos < nb) begin
			unit_c = repl_unit;
			st_c = ST_REPL;
		end else if (jrel < mlen) begin
			case (head.kind)
				MK_BAD: begin
					unit_c = repl_unit;
					st_c = ST_REPL;
				end
				MK_PAIR: begin
					unit_c = (jrel == 3'd0)
						? 16'(head.value[20:10]) + HI_OFFSET
						: {6'd0, head.value[9:0]} + LO_OFFSET;
					st_c = ST_VALID;
				end
				default: begin
					unit_c = head.value[15:0];
					st_c = ST_VALID;
				end
			endcase
		end else begin
			unit_c = '0;
			st_c = ST_INCOMPLETE;
		end
		cnt_inc = (st_c == ST_REPL && cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
	end

	assign slot_free = !ov_q || ready;
	assign last = (total == 3'd0) || (pos == total - 3'd1);
	assign step = !empty && (total == 3'd0 || slot_free);
	assign emit = step && (total != 3'd0);
	assign pop  = step && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (step) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
				if (last && head.fin) begin
					cnt_q <= '0;
				end else if (emit) begin
					cnt_q <= cnt_inc;
				end
			end
			if (slot_free) begin
				ov_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			unit_q <= unit_c;
			st_q <= st_c;
			tot_q <= cnt_inc;
			end_q <= last;
		end
	end

	assign valid = ov_q;
	assign code_unit = unit_q;
	assign status = st_q;
	assign invalid_total = tot_q;
	assign run_end = end_q;

endmodule

### sv/u2u_chk.sv
// Port-level checks on the unit channel of the decoder.
module u2u_chk
	import u2u_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [15:0] code_unit,
	input logic [1:0]  status,
	input logic [15:0] invalid_total,
	input logic        run_end
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("unit word dropped while stalled");

	// status is one of the three codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (status == ST_VALID || status == ST_REPL || status == ST_INCOMPLETE))
		else $error("bad status code");

	// incomplete marker is always the last word of its byte and carries a zero unit
	a_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_INCOMPLETE |-> run_end && code_unit == 16'd0)
		else $error("malformed incomplete marker");

	// a replacement is counted in its own total
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_REPL |-> invalid_total != 16'd0)
		else $error("replacement not counted");

endmodule

bind utf8_to_utf16_stream_decoder u2u_chk chk_i (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (units_ch.valid),
	.ready         (units_ch.ready),
	.code_unit     (units_ch.code_unit),
	.status        (units_ch.status),
	.invalid_total (units_ch.invalid_total),
	.run_end       (units_ch.run_end)
);
